// ===== rtl/ajd_pkg.sv =====
// Package for the accelerometer jump detector: register indexes, reset values,
// axis codes and the configuration struct. No dependencies.
`default_nettype none
package ajd_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int ALPHA_BITS        = 16;
	localparam int AXIS_BITS         = 2;
	localparam int CFG_DATA_BITS     = 16;
	localparam int CFG_ADDR_BITS     = 3;
	localparam int TIME_BITS         = 32;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_AXIS_SELECT     = 3'd0,
		REG_SMOOTHING_ALPHA = 3'd1,
		REG_JUMP_THRESHOLD  = 3'd2,
		REG_REARM_THRESHOLD = 3'd3,
		REG_COOLDOWN_MS     = 3'd4
	} reg_idx_t;

	typedef enum logic [AXIS_BITS-1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	localparam logic [AXIS_BITS-1:0]     AXIS_SELECT_RST     = 2'd2;
	localparam logic [CFG_DATA_BITS-1:0] SMOOTHING_ALPHA_RST = 16'd58982;
	localparam logic [CFG_DATA_BITS-1:0] JUMP_THRESHOLD_RST  = 16'd2867;
	localparam logic [CFG_DATA_BITS-1:0] REARM_THRESHOLD_RST = 16'd819;
	localparam logic [CFG_DATA_BITS-1:0] COOLDOWN_MS_RST     = 16'd400;

	typedef struct packed {
		logic [AXIS_BITS-1:0]     axis_select;
		logic [ALPHA_BITS-1:0]    smoothing_alpha;
		logic [CFG_DATA_BITS-1:0] jump_threshold;
		logic [CFG_DATA_BITS-1:0] rearm_threshold;
		logic [CFG_DATA_BITS-1:0] cooldown_ms;
	} cfg_t;

	typedef struct packed {
		logic jump;
		logic is_armed;
	} flags_t;

endpackage
`default_nettype wire

// ===== rtl/ajd_cfg.sv =====
// Configuration register file of the jump detector.
// Depends on ajd_pkg.
`default_nettype none
module ajd_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ajd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  wire logic [ajd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output      ajd_pkg::cfg_t                      cfg
);
	import ajd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_select     <= AXIS_SELECT_RST;
			cfg_q.smoothing_alpha <= SMOOTHING_ALPHA_RST;
			cfg_q.jump_threshold  <= JUMP_THRESHOLD_RST;
			cfg_q.rearm_threshold <= REARM_THRESHOLD_RST;
			cfg_q.cooldown_ms     <= COOLDOWN_MS_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_AXIS_SELECT:     cfg_q.axis_select     <= cfg_wdata[AXIS_BITS-1:0];
				REG_SMOOTHING_ALPHA: cfg_q.smoothing_alpha <= cfg_wdata[ALPHA_BITS-1:0];
				REG_JUMP_THRESHOLD:  cfg_q.jump_threshold  <= cfg_wdata;
				REG_REARM_THRESHOLD: cfg_q.rearm_threshold <= cfg_wdata;
				REG_COOLDOWN_MS:     cfg_q.cooldown_ms     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/ajd_core.sv =====
// Gravity filter, dynamic part, arm/cooldown logic and the detector state.
// Depends on ajd_pkg.
`default_nettype none
module ajd_core #(
	parameter int SAMPLE_BITS   = ajd_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = ajd_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             fire,
	input  wire logic signed [SAMPLE_BITS-1:0]    sample,
	input  wire logic [ajd_pkg::TIME_BITS-1:0]    time_ms,
	input  wire ajd_pkg::cfg_t                    cfg,
	output      ajd_pkg::flags_t                  flags,
	output      logic signed [SAMPLE_BITS:0]      dynamic_accel
);
	import ajd_pkg::*;

	localparam int G_W   = SAMPLE_BITS + 1 + FRACTION_BITS;
	localparam int E_W   = G_W + 1;
	localparam int P_W   = E_W + ALPHA_BITS + 1;
	localparam int LIM_W = CFG_DATA_BITS + FRACTION_BITS + 1;
	localparam int CMP_W = (E_W > LIM_W) ? E_W : LIM_W;

	logic signed [G_W-1:0]       grav_q;
	logic                        seeded_q;
	logic                        armed_q;
	logic [TIME_BITS-1:0]        last_jump_q;

	logic signed [G_W-1:0]       sq;
	logic signed [E_W-1:0]       err;
	logic signed [ALPHA_BITS:0]  alpha_s;
	logic signed [P_W-1:0]       prod;
	logic signed [E_W-1:0]       corr;
	logic signed [E_W-1:0]       sum;
	logic signed [E_W-1:0]       dyn;
	logic [E_W-1:0]              mag;
	logic [CMP_W-1:0]            mag_c;
	logic [CMP_W-1:0]            rearm_c;
	logic signed [CMP_W-1:0]     dyn_c;
	logic signed [CMP_W-1:0]     jump_c;
	logic [TIME_BITS-1:0]        elapsed;
	logic                        armed_mid;
	logic                        jump;

	// new g = sq + floor(alpha*(g - sq) / 2^16); unseeded g behaves as g = sq
	assign sq      = {sample[SAMPLE_BITS-1], sample, {FRACTION_BITS{1'b0}}};
	assign err     = seeded_q ? ({grav_q[G_W-1], grav_q} - {sq[G_W-1], sq}) : '0;
	assign alpha_s = signed'({1'b0, cfg.smoothing_alpha});
	assign prod    = err * alpha_s;
	assign corr    = prod[ALPHA_BITS +: E_W];
	assign sum     = {sq[G_W-1], sq} + corr;
	assign dyn     = -corr;
	assign mag     = dyn[E_W-1] ? E_W'(-dyn) : E_W'(dyn);

	assign mag_c   = CMP_W'(mag);
	assign rearm_c = CMP_W'({cfg.rearm_threshold, {FRACTION_BITS{1'b0}}});
	assign dyn_c   = CMP_W'(dyn);
	assign jump_c  = signed'(CMP_W'({cfg.jump_threshold, {FRACTION_BITS{1'b0}}}));
	assign elapsed = time_ms - last_jump_q;

	assign armed_mid = armed_q | (mag_c < rearm_c);
	assign jump      = armed_mid && (dyn_c > jump_c)
		&& (elapsed > TIME_BITS'(cfg.cooldown_ms));

	assign flags          = '{jump: jump, is_armed: armed_mid & ~jump};
	assign dynamic_accel  = dyn[FRACTION_BITS +: SAMPLE_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q      <= '0;
			seeded_q    <= 1'b0;
			armed_q     <= 1'b1;
			last_jump_q <= '0;
		end else if (fire) begin
			grav_q   <= sum[G_W-1:0];
			seeded_q <= 1'b1;
			armed_q  <= armed_mid & ~jump;
			if (jump) begin
				last_jump_q <= time_ms;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/accel_jump_detector_top.sv =====
// Top level of the accelerometer jump detector: stream ports, input and result
// registers. Depends on ajd_pkg, ajd_cfg and ajd_core.
//
// A sample is taken on every clock in which the input is valid and ready and
// passes through the input register and the result register; a new sample may
// follow every cycle while the output is not stalled, with the filter multiply,
// threshold compares and cooldown check done combinationally in between. The
// first sample after reset seeds the gravity estimate. The result register
// holds a finished result while the next sample waits in the input register,
// so input ready drops only when both are full and the output is stalled.
// Registers may be written only while no sample is in flight.
`default_nettype none
module accel_jump_detector_top #(
	parameter int SAMPLE_BITS   = ajd_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = ajd_pkg::FRACTION_BITS_DEF,
	localparam int IN_W  = ((3*SAMPLE_BITS + ajd_pkg::TIME_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 3 + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ajd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [ajd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	// sample_x, sample_y, sample_z, time_ms, zero fill
	input  wire logic [IN_W-1:0]                   s_axis_tdata,
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// jump, is_armed, dynamic_accel, zero fill
	output      logic [OUT_W-1:0]                  m_axis_tdata
);
	import ajd_pkg::*;

	cfg_t                          cfg;
	flags_t                        flags;
	logic signed [SAMPLE_BITS:0]   dyn;

	logic                          vld_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [TIME_BITS-1:0]          time_s1;

	logic                          out_vld_q;
	logic                          jump_q;
	logic                          armed_q;
	logic signed [SAMPLE_BITS:0]   dyn_q;

	logic                          adv;
	logic                          fire;
	logic signed [SAMPLE_BITS-1:0] smp_sel;

	ajd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ajd_core #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.sample        (smp_s1),
		.time_ms       (time_s1),
		.cfg           (cfg),
		.flags         (flags),
		.dynamic_accel (dyn)
	);

	// unused axis code watches z
	always_comb begin
		case (axis_t'(cfg.axis_select))
			AXIS_X:  smp_sel = s_axis_tdata[0 +: SAMPLE_BITS];
			AXIS_Y:  smp_sel = s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS];
			default: smp_sel = s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
		endcase
	end

	assign adv           = !out_vld_q || m_axis_tready;
	assign fire          = vld_s1 && adv;
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			smp_s1  <= smp_sel;
			time_s1 <= s_axis_tdata[3*SAMPLE_BITS +: TIME_BITS];
		end
		if (fire) begin
			jump_q  <= flags.jump;
			armed_q <= flags.is_armed;
			dyn_q   <= dyn;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'({dyn_q, armed_q, jump_q});

	// a sample leaving the input register always lands in the result register
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_axis_tvalid)
		else $error("result lost after transfer from input register");

	// a held input register must back-pressure the input
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |-> !s_axis_tready)
		else $error("input register overwritten while stalled");

	// a jump always disarms
	a_jump_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && jump_q) |-> !armed_q)
		else $error("jump reported while still armed");

endmodule
`default_nettype wire

// ===== tb/ajd_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the accelerometer jump detector: watches the register port and both
// stream channels, predicts every result and compares it. Depends on ajd_pkg.
module ajd_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ajd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [ajd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [79:0]                       s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [23:0]                       m_tdata,
	output int                                mismatches,
	output int                                results_pending
);
	import ajd_pkg::*;

	localparam int SW    = SAMPLE_BITS_DEF;
	localparam int FW    = FRACTION_BITS_DEF;
	localparam int DYN_W = SW + 1;
	localparam int OUT_W = ((SW + 3 + 7) / 8) * 8;

	// packed from the top down: zero fill, dynamic_accel, is_armed, jump
	typedef struct packed {
		logic [OUT_W-DYN_W-3:0] fill;
		logic [DYN_W-1:0]       dyn;
		logic                   is_armed;
		logic                   jump;
	} detector_out_t;

	cfg_t            regs;
	longint          gravity;
	bit              seeded;
	bit              armed;
	logic [31:0]     prev_jump_ms;
	detector_out_t   expected_results[$];

	function automatic detector_out_t advance_detector(input logic [79:0] word);
		logic signed [SW-1:0] sx, sy, sz;
		logic [31:0]          now, elapsed;
		longint               s, sq, d, mag, a, rearm_q, jump_q, dyn_full;
		detector_out_t        r;
		sx  = word[SW-1:0];
		sy  = word[2*SW-1:SW];
		sz  = word[3*SW-1:2*SW];
		now = word[3*SW+31:3*SW];
		case (regs.axis_select)
			AXIS_X:  s = sx;
			AXIS_Y:  s = sy;
			default: s = sz;
		endcase
		sq = s <<< FW;
		if (!seeded) begin
			gravity = sq;
			seeded  = 1'b1;
		end
		a       = regs.smoothing_alpha;
		gravity = (a * gravity + ((longint'(1) <<< ALPHA_BITS) - a) * sq) >>> ALPHA_BITS;
		d       = sq - gravity;
		mag     = (d < 0) ? -d : d;
		rearm_q = regs.rearm_threshold;
		rearm_q = rearm_q <<< FW;
		jump_q  = regs.jump_threshold;
		jump_q  = jump_q <<< FW;
		if (mag < rearm_q)
			armed = 1'b1;
		elapsed = now - prev_jump_ms;   // wraps modulo 2^32
		r = '0;
		if (armed && d > jump_q && elapsed > regs.cooldown_ms) begin
			r.jump       = 1'b1;
			prev_jump_ms = now;
			armed        = 1'b0;
		end
		r.is_armed = armed;
		dyn_full   = d >>> FW;
		r.dyn      = dyn_full[DYN_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		detector_out_t want, got;
		if (!arst_n) begin
			regs.axis_select     = AXIS_SELECT_RST;
			regs.smoothing_alpha = SMOOTHING_ALPHA_RST;
			regs.jump_threshold  = JUMP_THRESHOLD_RST;
			regs.rearm_threshold = REARM_THRESHOLD_RST;
			regs.cooldown_ms     = COOLDOWN_MS_RST;
			gravity         = 0;
			seeded          = 1'b0;
			armed           = 1'b1;
			prev_jump_ms    = '0;
			expected_results.delete();
			mismatches      = 0;
			results_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_AXIS_SELECT:     regs.axis_select     = cfg_wdata[AXIS_BITS-1:0];
					REG_SMOOTHING_ALPHA: regs.smoothing_alpha = cfg_wdata;
					REG_JUMP_THRESHOLD:  regs.jump_threshold  = cfg_wdata;
					REG_REARM_THRESHOLD: regs.rearm_threshold = cfg_wdata;
					REG_COOLDOWN_MS:     regs.cooldown_ms     = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$error("result transfer with no sample outstanding: %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.jump !== want.jump) begin
						$error("jump: expected %0d, got %0d", want.jump, got.jump);
						mismatches++;
					end
					if (got.is_armed !== want.is_armed) begin
						$error("is_armed: expected %0d, got %0d", want.is_armed, got.is_armed);
						mismatches++;
					end
					if (got.dyn !== want.dyn) begin
						$error("dynamic_accel: expected %0d, got %0d",
							$signed(want.dyn), $signed(got.dyn));
						mismatches++;
					end
					if (got.fill !== want.fill) begin
						$error("zero fill: expected %h, got %h", want.fill, got.fill);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(advance_detector(s_tdata));
			results_pending = expected_results.size();
		end
	end

endmodule

// ===== tb/tb_accel_jump_detector_top.sv =====
`timescale 1ns / 1ps
// Testbench top for accel_jump_detector_top: clock, reset, register writes, sample stimulus
// and receiver stalls; prediction lives in ajd_result_checker. Depends on ajd_pkg.
module tb_accel_jump_detector_top;
	import ajd_pkg::*;

	localparam int IN_W          = ((3*SAMPLE_BITS_DEF + TIME_BITS + 7) / 8) * 8;
	localparam int OUT_W         = ((SAMPLE_BITS_DEF + 3 + 7) / 8) * 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SAMPLE_TARGET = 1550;
	localparam int LAST_PHASE    = 150;
	localparam int S_MIN         = -32768;
	localparam int S_MAX         = 32767;

	// unmapped register indexes and the unused axis code
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_SPARE_FIRST = 3'd5;
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_SPARE_LAST  = 3'd7;
	localparam logic [AXIS_BITS-1:0]     AXIS_SPARE       = 2'd3;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_we        = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr      = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata     = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// sample_x, sample_y, sample_z, time_ms
	logic [IN_W-1:0]          s_axis_tdata  = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// jump, is_armed, dynamic_accel, zero fill
	logic [OUT_W-1:0]         m_axis_tdata;

	int                       mismatches;
	int                       results_pending;
	int                       quiet_cycles  = 0;
	int                       gap_odds      = 0;
	int                       stall_odds    = 0;
	int                       stall_left    = 0;
	int                       samples_sent  = 0;
	int                       phase_len     = 0;
	logic                     in_taken      = 1'b0;
	logic [31:0]              clock_ms      = '0;
	logic [AXIS_BITS-1:0]     watched_axis  = AXIS_SELECT_RST;

	accel_jump_detector_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ajd_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_axis_tvalid),
		.s_tready        (s_axis_tready),
		.s_tdata         (s_axis_tdata),
		.m_tvalid        (m_axis_tvalid),
		.m_tready        (m_axis_tready),
		.m_tdata         (m_axis_tdata),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	always #5 clk = ~clk;

	// flags an accepted input transfer for the driver, read at the following falling edge
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
	end

	// receiver stalls in random bursts; none once the odds drop to zero
	always @(negedge clk) begin
		if (stall_left > 0 && stall_odds != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(0, 12);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("accel_jump_detector_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic push_sample(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [31:0] t);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tdata  <= {t, z, y, x};
		s_axis_tvalid <= 1'b1;
		do @(negedge clk); while (!in_taken);
		samples_sent++;
	endtask

	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// wait until every result is out and the pipeline has emptied
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_registers(input logic [15:0] axis_word, input logic [15:0] alpha,
			input logic [15:0] jump_th, input logic [15:0] rearm_th,
			input logic [15:0] cooldown, input bit touch_spare);
		drain();
		write_reg(REG_AXIS_SELECT, axis_word);
		write_reg(REG_SMOOTHING_ALPHA, alpha);
		write_reg(REG_JUMP_THRESHOLD, jump_th);
		write_reg(REG_REARM_THRESHOLD, rearm_th);
		write_reg(REG_COOLDOWN_MS, cooldown);
		if (touch_spare)
			for (int a = ADDR_SPARE_FIRST; a <= ADDR_SPARE_LAST; a++)
				write_reg(CFG_ADDR_BITS'(a), 16'($urandom));
		cfg_we <= 1'b0;
		watched_axis = axis_word[AXIS_BITS-1:0];
	endtask

	task automatic shuffle_registers();
		logic [15:0] axis_word, alpha, jump_th, rearm_th, cooldown;
		axis_word = 16'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			axis_word[15:AXIS_BITS] = 14'($urandom);
		case ($urandom_range(0, 7))
			0:       alpha = '0;
			1:       alpha = 16'hFFFF;
			2:       alpha = 16'($urandom);
			default: alpha = 16'($urandom_range(45000, 64000));
		endcase
		case ($urandom_range(0, 7))
			0:       jump_th = '0;
			1:       jump_th = 16'hFFFF;
			default: jump_th = 16'($urandom_range(500, 8000));
		endcase
		case ($urandom_range(0, 7))
			0:       rearm_th = '0;
			1:       rearm_th = 16'hFFFF;
			default: rearm_th = 16'($urandom_range(100, 2500));
		endcase
		case ($urandom_range(0, 7))
			0:       cooldown = '0;
			1:       cooldown = 16'hFFFF;
			default: cooldown = 16'($urandom_range(0, 1000));
		endcase
		program_registers(axis_word, alpha, jump_th, rearm_th, cooldown,
			$urandom_range(0, 2) == 0);
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 2;
			2:       return 5;
			default: return 12;
		endcase
	endfunction

	// a noisy baseline on the watched axis with occasional impulses, plus some raw noise
	task automatic run_phase(input int count);
		int          base, noise, level, watch;
		logic [15:0] lane [3];
		base  = int'($urandom_range(0, 40000)) - 20000;
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 500);
		watch = (watched_axis == AXIS_X) ? 0 : (watched_axis == AXIS_Y) ? 1 : 2;
		if ($urandom_range(0, 3) == 0)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		repeat (count) begin
			for (int k = 0; k < 3; k++)
				lane[k] = 16'($urandom);
			clock_ms += ($urandom_range(0, 29) == 0) ? $urandom_range(0, 70000)
				: $urandom_range(1, 250);
			if ($urandom_range(0, 9) != 0) begin
				if ($urandom_range(0, 49) == 0)
					base = int'($urandom_range(0, 40000)) - 20000;
				level = base + int'($urandom_range(0, 2*noise)) - noise;
				if ($urandom_range(0, 11) == 0)
					level += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(3000, 30000));
				if (level > S_MAX) level = S_MAX;
				if (level < S_MIN) level = S_MIN;
				lane[watch] = 16'(level);
			end else begin
				clock_ms = $urandom;
			end
			push_sample(lane[0], lane[1], lane[2], clock_ms);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		gap_odds   = 4;
		stall_odds <= 4;

		// reset settings, z watched: seeding, cooldown hold-off, jump, disarm and re-arm
		push_sample(16'h7FFF, 16'h8000, 16'h0000, 32'd0);
		push_sample(16'h8000, 16'h7FFF, 16'h7FFF, 32'd300);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'd401);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'd900);
		push_sample(16'h0000, 16'h0000, 16'd11268, 32'd1000);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'd1300);
		push_sample(16'h0000, 16'h0000, 16'd13418, 32'd1500);
		// elapsed equal to the cooldown must not trigger, one more millisecond may
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'd1700);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'd1701);
		// timestamp wrap across a jump
		push_sample(16'hFFFF, 16'hFFFF, 16'd20000, 32'hFFFF_FF00);
		push_sample(16'hFFFF, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF);
		push_sample(16'h5555, 16'hAAAA, 16'h8000, 32'h0000_0100);
		push_sample(16'hAAAA, 16'h5555, 16'd20000, 32'h0000_0180);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'h0000_0191);

		// axis code with stray upper bits selects x; alpha zero follows the sample exactly
		program_registers(16'hFFFC, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
		push_sample(16'h8000, 16'h1234, 16'h4321, 32'd10);
		push_sample(16'h7FFF, 16'h1234, 16'h4321, 32'd11);
		push_sample(16'hFFFF, 16'h1234, 16'h4321, 32'd12);
		// unused axis code watches z; heaviest smoothing, jump threshold and cooldown at the top, rearm threshold zero
		program_registers({14'd0, AXIS_SPARE}, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
		push_sample(16'h0000, 16'h0000, 16'h8000, 32'd20);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 32'd70000);
		push_sample(16'h0000, 16'h0000, 16'h8000, 32'd140000);
		// y watched, zero jump threshold and cooldown, rearm threshold at the top
		program_registers({14'd0, AXIS_Y}, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
		push_sample(16'h0000, 16'h8000, 16'h0000, 32'd5);
		push_sample(16'h0000, 16'h7FFF, 16'h0000, 32'd6);
		push_sample(16'h0000, 16'h7FFF, 16'h0000, 32'd6);
		push_sample(16'h0000, 16'h8000, 16'h0000, 32'd7);

		while (samples_sent < SAMPLE_TARGET - LAST_PHASE) begin
			shuffle_registers();
			gap_odds   = pick_odds();
			stall_odds <= pick_odds();
			phase_len  = $urandom_range(100, 220);
			if (phase_len > SAMPLE_TARGET - LAST_PHASE - samples_sent)
				phase_len = SAMPLE_TARGET - LAST_PHASE - samples_sent;
			run_phase(phase_len);
		end
		gap_odds   = 0;
		stall_odds <= 0;
		shuffle_registers();
		run_phase(LAST_PHASE);
		drain();

		if (mismatches == 0 && results_pending == 0)
			$display("accel_jump_detector_top test passed");
		else
			$display("accel_jump_detector_top test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ajd_pkg.sv
rtl/ajd_cfg.sv
rtl/ajd_core.sv
rtl/accel_jump_detector_top.sv
tb/ajd_result_checker.sv
tb/tb_accel_jump_detector_top.sv
